FILE: hdl/mid_pkg.sv
// shared constants for the minimum image distance block
package mid_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int BOX_WIDTH       = 23;
  localparam int DSQ_WIDTH       = 50;
  localparam int DIST_WIDTH      = 25;
  localparam int CFG_IDX_WIDTH   = 1;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_PERIODIC_ENABLE = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BOX_LENGTH      = 1'd1;

  localparam logic                 PERIODIC_RESET = 1'b1;
  localparam logic [BOX_WIDTH-1:0] BOX_RESET      = 23'd1048576;

endpackage

FILE: hdl/mid_div_cell.sv
// one restoring division step on three lanes, remainder by box length
module mid_div_cell #(
  parameter int W = mid_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic [2:0][W-1:0]                     in_mag,
  input  logic [2:0][W-1:0]                     in_shift,
  input  logic [2:0][mid_pkg::BOX_WIDTH-1:0]    in_rem,
  input  logic [mid_pkg::BOX_WIDTH-1:0]         box_length,
  output logic                                  out_valid,
  output logic [2:0][W-1:0]                     out_mag,
  output logic [2:0][W-1:0]                     out_shift,
  output logic [2:0][mid_pkg::BOX_WIDTH-1:0]    out_rem
);

  localparam int BW = mid_pkg::BOX_WIDTH;

  logic [2:0][BW-1:0] rem_next;
  logic [2:0][W-1:0]  shift_next;

  always_comb begin
    logic [BW:0] rs;
    for (int i = 0; i < 3; i++) begin
      rs = {in_rem[i], in_shift[i][W-1]};
      if (rs >= {1'b0, box_length}) begin
        rem_next[i] = BW'(rs - {1'b0, box_length});
      end else begin
        rem_next[i] = rs[BW-1:0];
      end
      shift_next[i] = in_shift[i] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_mag   <= in_mag;
    out_shift <= shift_next;
    out_rem   <= rem_next;
  end

endmodule

FILE: hdl/mid_sqrt_cell.sv
// one digit of the restoring integer square root
module mid_sqrt_cell #(
  parameter int RB = mid_pkg::COORD_WIDTH_DEF + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [2*RB-1:0]   in_sq,
  input  logic [2*RB-1:0]   in_shift,
  input  logic [RB+1:0]     in_rem,
  input  logic [RB-1:0]     in_root,
  output logic              out_valid,
  output logic [2*RB-1:0]   out_sq,
  output logic [2*RB-1:0]   out_shift,
  output logic [RB+1:0]     out_rem,
  output logic [RB-1:0]     out_root
);

  logic [RB+3:0] rs;
  logic [RB+3:0] trial;
  logic          ge;

  assign rs    = {in_rem, in_shift[2*RB-1:2*RB-2]};
  assign trial = (RB+4)'({in_root, 2'b01});
  assign ge    = rs >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_sq    <= in_sq;
    out_shift <= in_shift << 2;
    out_rem   <= ge ? (RB+2)'(rs - trial) : rs[RB+1:0];
    out_root  <= {in_root[RB-2:0], ge};
  end

endmodule

FILE: hdl/minimum_image_distance.sv
// top level: minimum image distance between two points, pipelined
//
//  channel   | handshake            | fields
//  ----------+----------------------+------------------------------------------
//  input     | start, busy          | point_a_x/y/z, point_b_x/y/z
//  result    | result_valid strobe  | distance_squared, distance
//  config    | cfg_write            | cfg_index, cfg_data
//
// one transfer accepted every cycle, busy is always low
// the pipeline is the input stage, COORD_WIDTH division cells,
// fold, square, sum, then COORD_WIDTH+1 square root cells
// the division cells and the square root cells set the latency, one bit per cell
// synchronous reset clears the valid chain and loads register defaults
// the receiver cannot stall: each result shows for exactly one cycle
module minimum_image_distance #(
  parameter int COORD_WIDTH = mid_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [COORD_WIDTH-1:0]               point_a_x,
  input  logic [COORD_WIDTH-1:0]               point_a_y,
  input  logic [COORD_WIDTH-1:0]               point_a_z,
  input  logic [COORD_WIDTH-1:0]               point_b_x,
  input  logic [COORD_WIDTH-1:0]               point_b_y,
  input  logic [COORD_WIDTH-1:0]               point_b_z,
  output logic                                 result_valid,
  output logic [mid_pkg::DSQ_WIDTH-1:0]        distance_squared,
  output logic [mid_pkg::DIST_WIDTH-1:0]       distance,
  input  logic                                 cfg_write,
  input  logic [mid_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [mid_pkg::BOX_WIDTH-1:0]        cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int BW  = mid_pkg::BOX_WIDTH;
  localparam int RB  = W + 1;          // root bits
  localparam int SW  = 2 * RB;         // squared sum bits
  localparam int LAT = 2 * W + 5;

  // configuration registers
  logic          periodic_enable;
  logic [BW-1:0] box_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_enable <= mid_pkg::PERIODIC_RESET;
      box_length      <= mid_pkg::BOX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mid_pkg::REG_PERIODIC_ENABLE: periodic_enable <= cfg_data[0];
        mid_pkg::REG_BOX_LENGTH:      box_length      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage: absolute component differences
  logic [2:0][W-1:0] a_pt;
  logic [2:0][W-1:0] b_pt;
  logic [2:0][W-1:0] mag_in;
  logic              in_valid;
  logic [2:0][W-1:0] in_mag;

  assign a_pt = {point_a_z, point_a_y, point_a_x};
  assign b_pt = {point_b_z, point_b_y, point_b_x};

  always_comb begin
    logic [W:0] diff;
    for (int i = 0; i < 3; i++) begin
      diff = {a_pt[i][W-1], a_pt[i]} - {b_pt[i][W-1], b_pt[i]};
      mag_in[i] = diff[W] ? W'(-diff) : diff[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_mag <= mag_in;
  end

  // division chain: remainder of each magnitude by the box length
  logic [W:0]         dv_valid;
  logic [2:0][W-1:0]  dv_mag   [W+1];
  logic [2:0][W-1:0]  dv_shift [W+1];
  logic [2:0][BW-1:0] dv_rem   [W+1];

  assign dv_valid[0] = in_valid;
  assign dv_mag[0]   = in_mag;
  assign dv_shift[0] = in_mag;
  assign dv_rem[0]   = '0;

  for (genvar k = 0; k < W; k++) begin : g_div
    mid_div_cell #(.W(W)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (dv_valid[k]),
      .in_mag     (dv_mag[k]),
      .in_shift   (dv_shift[k]),
      .in_rem     (dv_rem[k]),
      .box_length (box_length),
      .out_valid  (dv_valid[k+1]),
      .out_mag    (dv_mag[k+1]),
      .out_shift  (dv_shift[k+1]),
      .out_rem    (dv_rem[k+1])
    );
  end

  // fold: wrap on maps a remainder at or past half box to box minus it, else keeps it; wrap off passes the magnitude
  logic              wrap;
  logic [2:0][W-1:0] fold_mag;
  logic              fd_valid;
  logic [2:0][W-1:0] fd_mag;

  assign wrap = periodic_enable && (box_length != '0);

  always_comb begin
    logic [BW:0]   twice;
    logic [BW-1:0] img;
    for (int i = 0; i < 3; i++) begin
      twice = {dv_rem[W][i], 1'b0};
      img   = (twice >= {1'b0, box_length}) ? box_length - dv_rem[W][i] : dv_rem[W][i];
      fold_mag[i] = wrap ? W'(img) : dv_mag[W][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fd_valid <= 1'b0;
    end else begin
      fd_valid <= dv_valid[W];
    end
    fd_mag <= fold_mag;
  end

  // squares, one multiplier per lane
  logic                sq_valid;
  logic [2:0][2*W-1:0] sq_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= fd_valid;
    end
    for (int i = 0; i < 3; i++) begin
      sq_term[i] <= fd_mag[i] * fd_mag[i];
    end
  end

  // sum of squares
  logic          sum_valid;
  logic [SW-1:0] sum_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else begin
      sum_valid <= sq_valid;
    end
    sum_sq <= SW'(sq_term[0]) + SW'(sq_term[1]) + SW'(sq_term[2]);
  end

  // square root chain, one root bit per cell
  logic [RB:0]   rt_valid;
  logic [SW-1:0] rt_sq    [RB+1];
  logic [SW-1:0] rt_shift [RB+1];
  logic [RB+1:0] rt_rem   [RB+1];
  logic [RB-1:0] rt_root  [RB+1];

  assign rt_valid[0] = sum_valid;
  assign rt_sq[0]    = sum_sq;
  assign rt_shift[0] = sum_sq;
  assign rt_rem[0]   = '0;
  assign rt_root[0]  = '0;

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    mid_sqrt_cell #(.RB(RB)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (rt_valid[k]),
      .in_sq     (rt_sq[k]),
      .in_shift  (rt_shift[k]),
      .in_rem    (rt_rem[k]),
      .in_root   (rt_root[k]),
      .out_valid (rt_valid[k+1]),
      .out_sq    (rt_sq[k+1]),
      .out_shift (rt_shift[k+1]),
      .out_rem   (rt_rem[k+1]),
      .out_root  (rt_root[k+1])
    );
  end

  assign result_valid     = rt_valid[RB];
  assign distance_squared = mid_pkg::DSQ_WIDTH'(rt_sq[RB]);
  assign distance         = mid_pkg::DIST_WIDTH'(rt_root[RB]);

`ifndef SYNTHESIS
  // every accepted transfer comes out after the pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT result_valid)
    else $error("result missing after pipeline latency");

  // root is the floor square root of the squared distance
  a_root_low: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (64'(distance) * 64'(distance) <= 64'(distance_squared)))
    else $error("root too large");

  a_root_high: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((64'(distance) + 64'd1) * (64'(distance) + 64'd1)
                      > 64'(distance_squared)))
    else $error("root too small");

  // twice the wrapped x magnitude never exceeds the box length plus one
  a_fold: assert property (@(posedge clk) disable iff (rst)
    (fd_valid && wrap) |-> ((BW+1)'({fd_mag[0], 1'b0}) <= (BW+1)'(box_length) + (BW+1)'(1)))
    else $error("wrapped x component beyond half box");
`endif

endmodule
